// ===== rtl/rmbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmbd_pkg
// shared types, register codes and trig table helpers for the box distance
// ray marcher
// ----------------------------------------------------------------------------
package rmbd_pkg;

	localparam int MAX_BOXES_DEF   = 8;
	localparam int ANGLE_STEPS_DEF = 4096;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_COUNT    = 2'd1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_CAST = 1'b1;

	localparam logic [8:0] MAX_DISTANCE_RST = 9'd300;
	localparam logic [3:0] BOX_COUNT_RST    = 4'd0;

	// angles in q30 radians
	localparam longint unsigned PI_Q30      = 64'd3373259426;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
	localparam longint ONE_Q14 = 64'd16384;

	localparam longint unsigned TAYLOR_DIV [1:6] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156
	};

	typedef struct packed {
		logic [9:0] left;
		logic [9:0] top;
		logic [9:0] width;
		logic [9:0] height;
	} box_t;

	// sine of a q30 angle in [0, 2*pi) as signed q1.14, evaluated at elaboration
	function automatic logic signed [15:0] sin_q14(input longint unsigned ang);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		longint q;
		logic neg;
		x = ang % TWO_PI_Q30;
		neg = 1'b0;
		if (x >= PI_Q30) begin
			neg = 1'b1;
			x = x - PI_Q30;
		end
		if (x > HALF_PI_Q30) begin
			x = PI_Q30 - x;
		end
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k];
			if (k % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		q = (sum + 64'sd32768) >>> 16;
		if (q > ONE_Q14) begin
			q = ONE_Q14;
		end
		return neg ? 16'(-q) : 16'(q);
	endfunction

endpackage

// ===== rtl/rmbd_if.sv =====
// ----------------------------------------------------------------------------
// rmbd interfaces
// request, result and register write channels of the box distance ray marcher
// ----------------------------------------------------------------------------
interface rmbd_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [2:0]  box_slot;
	logic [9:0]  box_left;
	logic [9:0]  box_top;
	logic [9:0]  box_width;
	logic [9:0]  box_height;
	logic [15:0] origin_x;
	logic [15:0] origin_y;
	logic [11:0] ray_heading;
	logic [11:0] view_heading;

	modport source (
		output valid, op, box_slot, box_left, box_top, box_width, box_height,
		output origin_x, origin_y, ray_heading, view_heading,
		input  ready
	);
	modport sink (
		input  valid, op, box_slot, box_left, box_top, box_width, box_height,
		input  origin_x, origin_y, ray_heading, view_heading,
		output ready
	);
endinterface

interface rmbd_rsp_if;
	logic        valid;
	logic        ready;
	logic [14:0] corrected_distance;
	logic        hit;

	modport source (output valid, corrected_distance, hit, input ready);
	modport sink   (input valid, corrected_distance, hit, output ready);
endinterface

interface rmbd_cfg_if;
	import rmbd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ray_march_box_distance.sv =====
// ----------------------------------------------------------------------------
// ray_march_box_distance
// marches a ray in unit steps against a small box table and returns the
// fisheye corrected hit distance
// ----------------------------------------------------------------------------
// box load: taken only in idle, no result transaction
// cast: states run reduction, difference, trig load, march steps, multiply and output;
//   steps is the hit step + 1, or max_distance on a miss
// one cast at a time; the march loop takes one step per cycle, all boxes per step
// reset clears control, sets max_distance 300 and box_count 0; box table is not
//   cleared and holds nothing valid until loaded
module ray_march_box_distance #(
	parameter int MAX_BOXES   = rmbd_pkg::MAX_BOXES_DEF,
	parameter int ANGLE_STEPS = rmbd_pkg::ANGLE_STEPS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	rmbd_req_if.sink    req,
	rmbd_rsp_if.source  rsp,
	rmbd_cfg_if.sink    cfg
);
	import rmbd_pkg::*;

	localparam int AW = $clog2(ANGLE_STEPS);
	localparam int CW = AW + 1;
	localparam int RW = (CW > 12) ? CW : 12;
	localparam int PW = 19;
	localparam logic [RW-1:0] STEPS_R = RW'(ANGLE_STEPS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RED   = 3'd1;
	localparam logic [2:0] ST_DIFF  = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_MARCH = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]  state_q;
	logic [8:0]  max_distance_q;
	logic [3:0]  box_count_q;
	box_t        box_q [MAX_BOXES];

	logic [15:0]        ox_q, oy_q;
	logic [RW-1:0]      ray_q, view_q;
	logic [AW-1:0]      diff_q;
	logic signed [15:0] cx_q, sy_q;
	logic [24:0]        acc_x_q, acc_y_q;
	logic [8:0]         d_q;
	logic [8:0]         raw_q;
	logic               hit_q;
	logic [23:0]        prod_q;

	logic        out_valid_q;
	logic [14:0] out_dist_q;
	logic        out_hit_q;

	// trig rom: {cos, sin} per heading step, built at elaboration
	logic [31:0]   trig_rom [ANGLE_STEPS];
	logic [31:0]   rom_q;
	logic [AW-1:0] rom_addr;

	for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_rom
		localparam longint unsigned ANG = (64'(g) * TWO_PI_Q30) / ANGLE_STEPS;
		localparam longint unsigned ANG_C = (ANG + HALF_PI_Q30 >= TWO_PI_Q30) ?
			ANG + HALF_PI_Q30 - TWO_PI_Q30 : ANG + HALF_PI_Q30;
		assign trig_rom[g] = {sin_q14(ANG_C), sin_q14(ANG)};
	end

	assign rom_addr = (state_q == ST_RED || state_q == ST_DIFF) ? AW'(ray_q) : diff_q;

	always_ff @(posedge clk) begin
		rom_q <= trig_rom[rom_addr];
	end

	// march point and parallel box test
	logic signed [PW-1:0] px, py;
	logic [MAX_BOXES-1:0] hit_vec;
	logic                 any_hit;

	assign px = $signed({3'b000, ox_q}) + $signed({{2{acc_x_q[24]}}, acc_x_q[24:8]});
	assign py = $signed({3'b000, oy_q}) + $signed({{2{acc_y_q[24]}}, acc_y_q[24:8]});

	for (genvar i = 0; i < MAX_BOXES; i++) begin : g_box
		logic [10:0]          right_e, bottom_e;
		logic signed [PW-1:0] l_b, t_b, r_b, b_b;
		assign right_e  = 11'(box_q[i].left) + 11'(box_q[i].width);
		assign bottom_e = 11'(box_q[i].top) + 11'(box_q[i].height);
		assign l_b = $signed({3'b000, box_q[i].left, 6'b0});
		assign t_b = $signed({3'b000, box_q[i].top, 6'b0});
		assign r_b = $signed({2'b00, right_e, 6'b0});
		assign b_b = $signed({2'b00, bottom_e, 6'b0});
		assign hit_vec[i] = (i < int'(box_count_q)) && (px >= l_b) && (px < r_b) &&
			(py >= t_b) && (py < b_b);
	end

	assign any_hit = |hit_vec;

	// heading difference, input below twice the step count
	logic [RW:0] dsum;
	assign dsum = {1'b0, ray_q} + {1'b0, STEPS_R} - {1'b0, view_q};

	logic signed [15:0] cc;
	assign cc = rom_q[31:16];

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q <= MAX_DISTANCE_RST;
			box_count_q    <= BOX_COUNT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MAX_DISTANCE: max_distance_q <= cfg.data[8:0];
				REG_BOX_COUNT:    box_count_q    <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_BOXES; i++) begin
			if (req.valid && req.ready && req.op == OP_LOAD && int'(req.box_slot) == i) begin
				box_q[i] <= '{req.box_left, req.box_top, req.box_width, req.box_height};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid && req.op == OP_CAST) begin
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					if (ray_q < STEPS_R && view_q < STEPS_R) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: state_q <= ST_LOAD;
				ST_LOAD: state_q <= (max_distance_q == 9'd0) ? ST_MUL : ST_MARCH;
				ST_MARCH: begin
					if (any_hit || d_q + 9'd1 == max_distance_q) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ox_q   <= req.origin_x;
				oy_q   <= req.origin_y;
				ray_q  <= RW'(req.ray_heading);
				view_q <= RW'(req.view_heading);
			end
			ST_RED: begin
				// one subtraction per cycle until both headings are in range
				if (ray_q >= STEPS_R) begin
					ray_q <= ray_q - STEPS_R;
				end else if (view_q >= STEPS_R) begin
					view_q <= view_q - STEPS_R;
				end
			end
			ST_DIFF: begin
				diff_q <= (dsum >= {1'b0, STEPS_R}) ? AW'(dsum - {1'b0, STEPS_R}) : AW'(dsum);
			end
			ST_LOAD: begin
				cx_q    <= rom_q[31:16];
				sy_q    <= rom_q[15:0];
				acc_x_q <= '0;
				acc_y_q <= '0;
				d_q     <= '0;
				raw_q   <= max_distance_q;
				hit_q   <= 1'b0;
			end
			ST_MARCH: begin
				if (any_hit) begin
					hit_q <= 1'b1;
					raw_q <= d_q + 9'd1;
				end else begin
					d_q     <= d_q + 9'd1;
					acc_x_q <= acc_x_q + {{9{cx_q[15]}}, cx_q};
					acc_y_q <= acc_y_q + {{9{sy_q[15]}}, sy_q};
				end
			end
			ST_MUL: begin
				// backward correction clamps to zero
				prod_q <= (cc <= 16'sd0) ? 24'd0 : 24'(raw_q) * 24'(cc[14:0]);
			end
			ST_OUT: begin
				if (!out_valid_q || rsp.ready) begin
					out_dist_q <= prod_q[23] ? 15'h7fff : prod_q[22:8];
					out_hit_q  <= hit_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.corrected_distance = out_dist_q;
	assign rsp.hit                = out_hit_q;

	a_march_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MARCH |-> d_q < max_distance_q)
		else $error("march step beyond limit");

	a_heading_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIFF |-> (ray_q < STEPS_R && view_q < STEPS_R))
		else $error("heading not reduced before lookup");

	a_cast_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.op == OP_CAST |=> state_q == ST_RED)
		else $error("cast transaction did not start a march");

	a_result_from_cast: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result without finished cast");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.op == OP_LOAD && !out_valid_q |=> !out_valid_q)
		else $error("box load produced a result");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for ray_march_box_distance: loads the box table, casts
// directed, aimed and random rays under changing limits, and checks every
// distance and hit flag against a behavioral march of the same table
// ----------------------------------------------------------------------------
module tb_top;
	import rmbd_pkg::*;

	localparam longint unsigned RAD_PI      = 64'd3373259426;
	localparam longint unsigned RAD_HALF_PI = 64'd1686629713;
	localparam longint unsigned RAD_TWO_PI  = 64'd6746518852;
	localparam int              TABLE_SIZE  = 8;
	localparam int              DIST_CAP    = 32767;
	localparam int              LIMIT_RST   = 300;

	typedef struct {
		bit        op;
		bit [2:0]  slot;
		bit [9:0]  left;
		bit [9:0]  top;
		bit [9:0]  width;
		bit [9:0]  height;
		bit [15:0] ox;
		bit [15:0] oy;
		bit [11:0] ray;
		bit [11:0] view;
	} ray_req_t;

	typedef struct {
		bit [14:0] distance;
		bit        hit;
	} ray_rsp_t;

	typedef struct {
		bit [CFG_IDX_W-1:0]  idx;
		bit [CFG_DATA_W-1:0] val;
	} reg_wr_t;

	typedef struct {
		int left;
		int top;
		int width;
		int height;
	} rect_t;

	logic clk = 1'b0;
	logic arst_n;

	rmbd_req_if req_ch ();
	rmbd_rsp_if rsp_ch ();
	rmbd_cfg_if cfg_ch ();

	ray_march_box_distance uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// model state, updated at each accepted transaction
	rect_t     boxes_seen [TABLE_SIZE];
	bit [8:0]  march_limit;
	bit [3:0]  box_total;
	ray_rsp_t  due_results [$];

	// stimulus side view of the table, used to aim casts
	rect_t     plan [TABLE_SIZE];
	int        plan_limit;
	int        plan_count;

	ray_req_t  req_backlog [$];
	reg_wr_t   reg_backlog [$];
	ray_req_t  on_wire;
	reg_wr_t   wr_on_wire;
	int        reqs_queued = 0;
	int        reqs_taken = 0;
	int        writes_queued = 0;
	int        writes_taken = 0;
	int        mismatches = 0;
	int        send_idle;
	int        recv_idle;
	bit        calm = 1'b0;

	always #10 clk = ~clk;

	// sine of a q30 angle as q1.14, taylor series through x^13 on a folded angle
	function automatic int sine_q14(longint unsigned rad);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned denom;
		longint acc;
		longint q;
		bit neg;
		x = rad % RAD_TWO_PI;
		neg = 1'b0;
		if (x >= RAD_PI) begin
			neg = 1'b1;
			x = x - RAD_PI;
		end
		if (x > RAD_HALF_PI)
			x = RAD_PI - x;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int k = 1; k <= 6; k++) begin
			denom = 2 * k * (2 * k + 1);
			term = ((term * x2) >> 30) / denom;
			if (k % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		q = (acc + 32768) >>> 16;
		if (q > 16384)
			q = 16384;
		return neg ? -int'(q) : int'(q);
	endfunction

	function automatic longint unsigned heading_rad(bit [11:0] a);
		longint unsigned w;
		w = a;
		return (w * RAD_TWO_PI) / 64'd4096;
	endfunction

	function automatic int sin_of(bit [11:0] a);
		return sine_q14(heading_rad(a));
	endfunction

	function automatic int cos_of(bit [11:0] a);
		longint unsigned x;
		x = heading_rad(a) + RAD_HALF_PI;
		if (x >= RAD_TWO_PI)
			x = x - RAD_TWO_PI;
		return sine_q14(x);
	endfunction

	// full march of one cast against the current table and limits
	function automatic ray_rsp_t march_predict(ray_req_t r);
		ray_rsp_t res;
		int cx, sy, cc, px, py, n;
		int lo_x, lo_y, hi_x, hi_y;
		int raw;
		longint prod;
		bit [11:0] diff;
		cx = cos_of(r.ray);
		sy = sin_of(r.ray);
		n = (box_total > TABLE_SIZE) ? TABLE_SIZE : box_total;
		raw = march_limit;
		res.hit = 1'b0;
		for (int d = 0; d < int'(march_limit) && !res.hit; d++) begin
			px = int'(r.ox) + ((cx * d) >>> 8);
			py = int'(r.oy) + ((sy * d) >>> 8);
			for (int i = 0; i < n; i++) begin
				lo_x = boxes_seen[i].left * 64;
				lo_y = boxes_seen[i].top * 64;
				hi_x = (boxes_seen[i].left + boxes_seen[i].width) * 64;
				hi_y = (boxes_seen[i].top + boxes_seen[i].height) * 64;
				// half-open bounds, points off the map are not wrapped
				if (!res.hit && px >= lo_x && px < hi_x && py >= lo_y && py < hi_y) begin
					res.hit = 1'b1;
					raw = d + 1;
				end
			end
		end
		diff = r.ray - r.view;
		cc = cos_of(diff);
		if (cc <= 0)
			prod = 0;
		else
			prod = (longint'(raw) * cc) >>> 8;
		if (prod > DIST_CAP)
			prod = DIST_CAP;
		res.distance = prod[14:0];
		return res;
	endfunction

	task automatic present(ray_req_t r);
		req_ch.op <= r.op;
		req_ch.box_slot <= r.slot;
		req_ch.box_left <= r.left;
		req_ch.box_top <= r.top;
		req_ch.box_width <= r.width;
		req_ch.box_height <= r.height;
		req_ch.origin_x <= r.ox;
		req_ch.origin_y <= r.oy;
		req_ch.ray_heading <= r.ray;
		req_ch.view_heading <= r.view;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			present('{default: 0});
			send_idle = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				reqs_taken++;
				if (on_wire.op == OP_LOAD)
					boxes_seen[on_wire.slot] = '{on_wire.left, on_wire.top,
						on_wire.width, on_wire.height};
				else
					due_results = {due_results, march_predict(on_wire)};
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_idle > 0) begin
					send_idle--;
					req_ch.valid <= 1'b0;
				end else if (req_backlog.size() != 0 && !calm && $urandom_range(0, 11) == 0) begin
					send_idle = $urandom_range(0, 16);
					req_ch.valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					on_wire = req_backlog.pop_front();
					present(on_wire);
					req_ch.valid <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and ready stalls
	always @(posedge clk or negedge arst_n) begin
		ray_rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_idle = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, expected none, got distance %0d hit %0d",
						$time, rsp_ch.corrected_distance, rsp_ch.hit);
				end else begin
					want = due_results.pop_front();
					if (rsp_ch.corrected_distance !== want.distance) begin
						mismatches++;
						$display("%0t: corrected_distance mismatch, expected %0d, got %0d",
							$time, want.distance, rsp_ch.corrected_distance);
					end
					if (rsp_ch.hit !== want.hit) begin
						mismatches++;
						$display("%0t: hit mismatch, expected %0d, got %0d",
							$time, want.hit, rsp_ch.hit);
					end
				end
			end
			if (recv_idle > 0) begin
				recv_idle--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 13) == 0) begin
				recv_idle = $urandom_range(0, 16);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// register write driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ch.valid <= 1'b0;
			cfg_ch.index <= REG_MAX_DISTANCE;
			cfg_ch.data <= '0;
			march_limit = LIMIT_RST;
			box_total = 4'd0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				writes_taken++;
				if (wr_on_wire.idx == REG_MAX_DISTANCE)
					march_limit = wr_on_wire.val[8:0];
				else if (wr_on_wire.idx == REG_BOX_COUNT)
					box_total = wr_on_wire.val[3:0];
			end
			if (!cfg_ch.valid || cfg_ch.ready) begin
				if (reg_backlog.size() != 0) begin
					wr_on_wire = reg_backlog.pop_front();
					cfg_ch.valid <= 1'b1;
					cfg_ch.index <= wr_on_wire.idx;
					cfg_ch.data <= wr_on_wire.val;
				end else begin
					cfg_ch.valid <= 1'b0;
				end
			end
		end
	end

	function automatic ray_req_t noise_req();
		ray_req_t r;
		r.op = $urandom_range(0, 1);
		r.slot = $urandom_range(0, 7);
		r.left = $urandom_range(0, 1023);
		r.top = $urandom_range(0, 1023);
		r.width = $urandom_range(0, 1023);
		r.height = $urandom_range(0, 1023);
		r.ox = $urandom_range(0, 65535);
		r.oy = $urandom_range(0, 65535);
		r.ray = $urandom_range(0, 4095);
		r.view = $urandom_range(0, 4095);
		return r;
	endfunction

	task automatic load_box(int slot, int l, int t, int w, int h);
		ray_req_t r;
		r = noise_req();
		r.op = OP_LOAD;
		r.slot = slot;
		r.left = l;
		r.top = t;
		r.width = w;
		r.height = h;
		plan[r.slot] = '{l, t, w, h};
		req_backlog = {req_backlog, r};
		reqs_queued++;
	endtask

	task automatic cast_ray(int ox, int oy, int ray, int view);
		ray_req_t r;
		r = noise_req();
		r.op = OP_CAST;
		r.ox = ox;
		r.oy = oy;
		r.ray = ray;
		r.view = view;
		req_backlog = {req_backlog, r};
		reqs_queued++;
	endtask

	task automatic random_cast();
		cast_ray($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 4095), $urandom_range(0, 4095));
	endtask

	task automatic random_load();
		int pick, w, h;
		pick = $urandom_range(0, 9);
		if (pick < 2) begin
			w = $urandom_range(0, 1023);
			h = $urandom_range(0, 1023);
		end else if (pick == 2) begin
			w = 0;
			h = $urandom_range(0, 60);
		end else if (pick == 3) begin
			w = $urandom_range(1, 60);
			h = 0;
		end else begin
			w = $urandom_range(1, 48);
			h = $urandom_range(1, 48);
		end
		load_box($urandom_range(0, 7), $urandom_range(0, 1023), $urandom_range(0, 1023), w, h);
	endtask

	// back the origin off from a point inside an active box so the march reaches it
	task automatic aimed_cast();
		int n, k, tx, ty, d, h, ox, oy;
		n = (plan_count > TABLE_SIZE) ? TABLE_SIZE : plan_count;
		k = (n > 0) ? $urandom_range(0, n - 1) : 0;
		if (n == 0 || plan[k].width == 0 || plan[k].height == 0) begin
			random_cast();
		end else begin
			tx = plan[k].left * 64 + $urandom_range(0, plan[k].width * 64 - 1);
			ty = plan[k].top * 64 + $urandom_range(0, plan[k].height * 64 - 1);
			d = $urandom_range(0, (plan_limit > 0) ? plan_limit - 1 : 0);
			h = $urandom_range(0, 4095);
			ox = tx - ((cos_of(h) * d) >>> 8);
			oy = ty - ((sin_of(h) * d) >>> 8);
			if (ox >= 0 && ox <= 65535 && oy >= 0 && oy <= 65535)
				cast_ray(ox, oy, h, h + $urandom_range(0, 2046) - 1023);
			else
				random_cast();
		end
	endtask

	// wait until every transaction is taken and answered, then let loads settle
	task automatic drain();
		while (reqs_taken != reqs_queued || writes_taken != writes_queued
				|| due_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_regs(int limit, int count);
		reg_wr_t wr;
		drain();
		wr.idx = REG_MAX_DISTANCE;
		wr.val = CFG_DATA_W'(limit);
		reg_backlog = {reg_backlog, wr};
		wr.idx = REG_BOX_COUNT;
		wr.val = CFG_DATA_W'(count);
		reg_backlog = {reg_backlog, wr};
		writes_queued += 2;
		plan_limit = limit;
		plan_count = count;
		while (writes_taken != writes_queued)
			@(posedge clk);
	endtask

	initial begin
		int limit, count, pick;
		arst_n <= 1'b0;
		plan_limit = LIMIT_RST;
		plan_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits, empty table: misses only
		cast_ray(0, 0, 0, 0);
		cast_ray(65535, 65535, 4095, 4095);
		cast_ray(100 * 64, 100 * 64, 1024, 0);
		cast_ray(100 * 64, 100 * 64, 3000, 952);

		load_box(0, 0, 0, 10, 10);
		load_box(1, 200, 200, 0, 50);
		load_box(2, 300, 300, 50, 0);
		load_box(3, 100, 100, 20, 20);
		load_box(4, 500, 600, 1, 1);
		load_box(5, 700, 700, 30, 30);
		load_box(6, 400, 800, 5, 5);
		load_box(7, 1023, 1023, 1023, 1023);

		set_regs(511, 8);
		cast_ray(5 * 64, 5 * 64, 0, 0);
		cast_ray(90 * 64, 110 * 64, 0, 0);
		cast_ray(130 * 64, 110 * 64, 2048, 2048);
		cast_ray(110 * 64, 90 * 64, 1024, 1024);
		cast_ray(200 * 64, 210 * 64, 0, 0);
		cast_ray(0, 500 * 64, 2048, 2048);
		cast_ray(65535, 65535, 512, 0);
		cast_ray(65000, 1023 * 64 + 10, 0, 4095);
		cast_ray(20 * 64, 5 * 64, 2048, 1025);

		for (int ph = 0; ph < 24; ph++) begin
			limit = $urandom_range(1, 96);
			count = $urandom_range(0, 15);
			case (ph)
				0: begin
					limit = 511;
					count = 8;
				end
				3: limit = 0;
				6: begin
					limit = 1;
					count = 15;
				end
				9: begin
					limit = 511;
					count = 0;
				end
				12: count = 9;
				default: ;
			endcase
			calm = (ph >= 21);
			set_regs(limit, count);
			for (int j = 0; j < 76; j++) begin
				pick = $urandom_range(0, 99);
				if (pick < 15)
					random_load();
				else if (pick < 75)
					aimed_cast();
				else
					random_cast();
			end
		end
		drain();

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rmbd_pkg.sv
rtl/rmbd_if.sv
rtl/ray_march_box_distance.sv
sim/tb_top.sv
